// ===== rtl/core/dual_battery_source_selector_defines.svh =====
// Assertion macros shared by the block's checking code.
`ifndef DUAL_BATTERY_SOURCE_SELECTOR_DEFINES_SVH
`define DUAL_BATTERY_SOURCE_SELECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dbss_pkg.sv =====
package dbss_pkg;

	localparam int SAMPLES = 16;
	localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

	localparam logic [15:0] LOW_LEVEL_RST = 16'd12000;
	localparam logic [15:0] LOWEST_LEVEL_RST = 16'd11000;
	localparam logic [15:0] GAIN_ONE_RST = 16'd17490;
	localparam logic [15:0] GAIN_TWO_RST = 16'd17540;

	localparam logic [1:0] REG_LOW_LEVEL = 2'd0;
	localparam logic [1:0] REG_LOWEST_LEVEL = 2'd1;
	localparam logic [1:0] REG_GAIN_ONE = 2'd2;
	localparam logic [1:0] REG_GAIN_TWO = 2'd3;

	typedef enum logic [2:0] {
		OUT_KEPT        = 3'd0,
		OUT_SWITCHED    = 3'd1,
		OUT_NO_CABLE    = 3'd2,
		OUT_BOTH_LOW    = 3'd3,
		OUT_NO_START    = 3'd4,
		OUT_NO_TAKEOVER = 3'd5
	} outcome_t;

	typedef struct packed {
		logic [11:0] sample_one;
		logic [11:0] sample_two;
		logic        cable_absent;
	} in_item_t;

	typedef struct packed {
		logic        relay_one;
		logic        relay_two;
		logic        regulator_on;
		logic        power_ok;
		outcome_t    outcome;
		logic [15:0] volts_one_mv;
		logic [15:0] volts_two_mv;
	} out_item_t;

	typedef struct packed {
		logic [15:0] low_level_mv;
		logic [15:0] lowest_level_mv;
		logic [15:0] gain_one;
		logic [15:0] gain_two;
	} cfg_t;

	typedef struct packed {
		logic [15:0] sum_one;
		logic [15:0] sum_two;
		logic        cable_absent;
	} window_t;

endpackage

// ===== rtl/core/dbss_cfg_regs.sv =====
module dbss_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output dbss_pkg::cfg_t    cfg
);

	dbss_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_level_mv <= dbss_pkg::LOW_LEVEL_RST;
			cfg_q.lowest_level_mv <= dbss_pkg::LOWEST_LEVEL_RST;
			cfg_q.gain_one <= dbss_pkg::GAIN_ONE_RST;
			cfg_q.gain_two <= dbss_pkg::GAIN_TWO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dbss_pkg::REG_LOW_LEVEL: cfg_q.low_level_mv <= cfg_data;
				dbss_pkg::REG_LOWEST_LEVEL: cfg_q.lowest_level_mv <= cfg_data;
				dbss_pkg::REG_GAIN_ONE: cfg_q.gain_one <= cfg_data;
				dbss_pkg::REG_GAIN_TWO: cfg_q.gain_two <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/dbss_accum.sv =====
module dbss_accum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dbss_pkg::in_item_t  in_item,
	output logic                win_valid,
	input  logic                win_ready,
	output dbss_pkg::window_t   win
);

	logic [dbss_pkg::CNT_W-1:0] count_q;
	logic [15:0]                sum_one_q;
	logic [15:0]                sum_two_q;
	logic [15:0]                sum_one_nxt;
	logic [15:0]                sum_two_nxt;
	logic                       win_valid_s1;
	dbss_pkg::window_t          win_s1;
	logic                       accept;
	logic                       last;

	assign in_stall = win_valid_s1 && !win_ready;
	assign accept = in_valid && !in_stall;
	assign last = (count_q == dbss_pkg::CNT_W'(dbss_pkg::SAMPLES - 1));
	assign sum_one_nxt = sum_one_q + {4'd0, in_item.sample_one};
	assign sum_two_nxt = sum_two_q + {4'd0, in_item.sample_two};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_one_q <= '0;
			sum_two_q <= '0;
		end else if (accept) begin
			if (last) begin
				count_q <= '0;
				sum_one_q <= '0;
				sum_two_q <= '0;
			end else begin
				count_q <= count_q + dbss_pkg::CNT_W'(1);
				sum_one_q <= sum_one_nxt;
				sum_two_q <= sum_two_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_s1 <= 1'b0;
		end else if (accept && last) begin
			win_valid_s1 <= 1'b1;
		end else if (win_ready) begin
			win_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			win_s1.sum_one <= sum_one_nxt;
			win_s1.sum_two <= sum_two_nxt;
			win_s1.cable_absent <= in_item.cable_absent;
		end
	end

	assign win_valid = win_valid_s1;
	assign win = win_s1;

endmodule

// ===== rtl/core/dbss_decide.sv =====
module dbss_decide (
	input  logic                clk,
	input  logic                arst_n,
	input  dbss_pkg::cfg_t      cfg,
	input  logic                win_valid,
	output logic                win_ready,
	input  dbss_pkg::window_t   win,
	output logic                out_valid,
	input  logic                out_stall,
	output dbss_pkg::out_item_t out_item
);

	logic                 one_on_q;
	logic                 two_on_q;
	logic                 first_q;
	logic                 reg_on_q;
	logic                 one_nxt;
	logic                 two_nxt;
	logic                 first_nxt;
	logic                 reg_nxt;
	logic [31:0]          prod_one;
	logic [31:0]          prod_two;
	logic [15:0]          v1;
	logic [15:0]          v2;
	logic [15:0]          start_th;
	dbss_pkg::outcome_t   outcome;
	logic                 power_off;
	logic                 take;
	logic                 out_valid_s2;
	dbss_pkg::out_item_t  out_item_s2;

	assign win_ready = !out_valid_s2 || !out_stall;
	assign take = win_valid && win_ready;

	// The 16 by 16 product shifted down by 16 never exceeds 65534, so the
	// saturation limit is never reached.
	assign prod_one = {16'd0, win.sum_one} * {16'd0, cfg.gain_one};
	assign prod_two = {16'd0, win.sum_two} * {16'd0, cfg.gain_two};
	assign v1 = prod_one[31:16];
	assign v2 = prod_two[31:16];
	assign start_th = first_q ? cfg.low_level_mv : cfg.lowest_level_mv;

	always_comb begin
		outcome = dbss_pkg::OUT_KEPT;
		one_nxt = one_on_q;
		two_nxt = two_on_q;
		first_nxt = first_q;
		reg_nxt = reg_on_q;
		if (win.cable_absent) begin
			outcome = dbss_pkg::OUT_NO_CABLE;
		end else if (v1 < cfg.lowest_level_mv && v2 < cfg.lowest_level_mv) begin
			outcome = dbss_pkg::OUT_BOTH_LOW;
		end else if (!one_on_q && !two_on_q) begin
			if (v1 > v2 && v1 > start_th) begin
				outcome = dbss_pkg::OUT_SWITCHED;
				one_nxt = 1'b1;
			end else if (v2 > start_th) begin
				outcome = dbss_pkg::OUT_SWITCHED;
				one_nxt = 1'b0;
			end else begin
				outcome = dbss_pkg::OUT_NO_START;
			end
		end else if (one_on_q && v1 < cfg.lowest_level_mv) begin
			if (v2 > cfg.low_level_mv) begin
				outcome = dbss_pkg::OUT_SWITCHED;
				one_nxt = 1'b0;
			end else begin
				outcome = dbss_pkg::OUT_NO_TAKEOVER;
			end
		end else if (two_on_q && v2 < cfg.lowest_level_mv) begin
			if (v1 > cfg.low_level_mv) begin
				outcome = dbss_pkg::OUT_SWITCHED;
				one_nxt = 1'b1;
			end else begin
				outcome = dbss_pkg::OUT_NO_TAKEOVER;
			end
		end
		power_off = (outcome != dbss_pkg::OUT_KEPT) && (outcome != dbss_pkg::OUT_SWITCHED);
		if (outcome == dbss_pkg::OUT_SWITCHED) begin
			two_nxt = !one_nxt;
			first_nxt = 1'b0;
			reg_nxt = 1'b1;
		end
		if (power_off) begin
			one_nxt = 1'b0;
			two_nxt = 1'b0;
			reg_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_on_q <= 1'b0;
			two_on_q <= 1'b0;
			first_q <= 1'b1;
			reg_on_q <= 1'b0;
		end else if (take) begin
			one_on_q <= one_nxt;
			two_on_q <= two_nxt;
			first_q <= first_nxt;
			reg_on_q <= reg_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (take) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_item_s2.relay_one <= one_nxt;
			out_item_s2.relay_two <= two_nxt;
			out_item_s2.regulator_on <= reg_nxt;
			out_item_s2.power_ok <= !power_off;
			out_item_s2.outcome <= outcome;
			out_item_s2.volts_one_mv <= v1;
			out_item_s2.volts_two_mv <= v2;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_item = out_item_s2;

endmodule

// ===== rtl/core/dual_battery_source_selector.sv =====
// Takes one pair of battery samples per cycle while in_stall is low. Every
// SAMPLES-th item closes a window and yields one result item: the window
// sums are registered, then one 16 by 16 multiply per battery feeds the
// threshold compares and relay decision in the next stage, which writes the
// output register. Items that do not close a window yield no result. The
// input side stalls only while a finished window waits behind a stalled
// output register. Configuration writes are taken at any edge with cfg_we
// high and must be made while the block is idle.
`include "dual_battery_source_selector_defines.svh"

module dual_battery_source_selector (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  dbss_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output dbss_pkg::out_item_t out_item
);

	dbss_pkg::cfg_t    cfg;
	dbss_pkg::window_t win;
	logic              win_valid;
	logic              win_ready;

	dbss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dbss_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win)
	);

	dbss_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	`DBSS_ASSERT_NOW(a_relays_exclusive, out_valid, !(out_item.relay_one && out_item.relay_two), "both relays closed")
	`DBSS_ASSERT_NOW(a_regulator_follows, out_valid, out_item.regulator_on == (out_item.relay_one || out_item.relay_two), "regulator does not match relays")
	`DBSS_ASSERT_NOW(a_stall_cause, in_stall, win_valid && out_valid && out_stall, "input stalled without a blocked window")
	`DBSS_ASSERT_NEXT(a_window_delivered, win_valid && win_ready, out_valid, "taken window gave no result")

endmodule
